/* src/pfx_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the postfix evaluator.
`default_nettype none

package pfx_pkg;

    // Operand width and stack sizing
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);
    localparam int SYM_W       = 8;
    localparam int STAT_W      = 3;

    // Expression characters
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

    // Status codes, first error kept
    typedef enum logic [STAT_W-1:0] {
        ERR_NONE    = 3'd0,
        ERR_UNDER   = 3'd1,
        ERR_OVER    = 3'd2,
        ERR_DIVZERO = 3'd3,
        ERR_BADSYM  = 3'd4
    } err_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // latch incoming symbol
        logic pop;       // pop stack top into read register
        logic load_r;    // capture popped value as right operand
        logic exec;      // evaluate operator
        logic push;      // push digit or result
        logic fin_load;  // load output register, clear stack and error
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_digit;  // symbol on the input port is a digit
        logic is_last;   // latched symbol ends the expression
        logic div_go;    // operator needs the divider
        logic div_done;  // divider quotient ready
    } stat_t;

endpackage

`default_nettype wire

/* src/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator: controller, datapath and checks.
//
// Usage:
//   Slave channel carries one expression character per transaction: s_tdata is
//   the character, s_tlast marks the final character of the expression.
//   Digits '0'..'9' push their value; + - * / pop right then left and push the
//   32-bit wrapped result (division truncates toward zero).
//   On the final character the stack top is popped and sent on the master
//   channel: m_tdata is the value, m_tuser the first error of the expression
//   (0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 bad symbol).
//   Then the stack and error are cleared for the next expression.
// Timing:
//   One character at a time. A digit is pushed directly; +, - and * pop right
//   and left, evaluate and push, and / also waits on the bit-per-cycle divider,
//   which a zero divisor skips. A final pop and output load follow a final character.
//   Stack memory is read and written through one port, one pop per cycle.
// Reset and stall:
//   rst_n clears stack count, error and handshake state; stack contents are
//   not cleared. The result waits in its output register while m_tready is
//   low; new characters are still taken until the next final output load needs it.
`default_nettype none

module postfix_expression_evaluator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic [2:0]       m_tuser    // [2:0] status
);

    pfx_pkg::cmd_t  cmd;
    pfx_pkg::stat_t st;
    pfx_pkg::err_t  status;

    pfx_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pfx_dpath u_dpath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .symbol (s_tdata),
        .last   (s_tlast),
        .cmd    (cmd),
        .st     (st),
        .value  (m_tdata),
        .status (status)
    );

    assign m_tuser = status;

    // One character in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    // Divider finishes only while an operator is being worked on
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> !s_tready)
        else $error("divider done outside of an operator");

    // Reported status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= pfx_pkg::ERR_BADSYM))
        else $error("undefined status code on output");

endmodule

`default_nettype wire

/* src/pfx_div.sv */
// Radix-2 restoring divider, signed truncating quotient, one bit per cycle.
`default_nettype none

module pfx_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pfx_pkg::DATA_W-1:0] dividend_mag,
    input  wire logic [pfx_pkg::DATA_W-1:0] divisor_mag,
    input  wire logic                       negate,
    output logic                            done,
    output logic [pfx_pkg::DATA_W-1:0]      quotient
);

    logic [pfx_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [pfx_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [pfx_pkg::DATA_W-1:0]    quo_reg, quo_next;
    logic [pfx_pkg::DATA_W-1:0]    div_reg;
    logic                          neg_reg;
    logic [pfx_pkg::DATA_W:0]      shifted;
    logic [pfx_pkg::DATA_W:0]      diff;
    logic                          fits;

    // One restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[pfx_pkg::DATA_W-1]};
        diff      = shifted - {1'b0, div_reg};
        fits      = (shifted >= {1'b0, div_reg});
        rem_next  = fits ? diff[pfx_pkg::DATA_W-1:0] : shifted[pfx_pkg::DATA_W-1:0];
        quo_next  = {quo_reg[pfx_pkg::DATA_W-2:0], fits};
        cnt_next  = cnt_reg - 1'b1;
        done_next = (cnt_reg == pfx_pkg::DIV_CNT_W'(1));
    end

    // Iteration counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= pfx_pkg::DIV_CNT_W'(pfx_pkg::DATA_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg != '0) && done_next;
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend_mag;
            div_reg <= divisor_mag;
            neg_reg <= negate;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

/* src/pfx_dpath.sv */
// Datapath: operand stack memory, count, sticky error, ALU and divider, output register.
`default_nettype none

module pfx_dpath
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [pfx_pkg::SYM_W-1:0] symbol,
    input  wire logic                      last,
    input  wire pfx_pkg::cmd_t             cmd,
    output pfx_pkg::stat_t                 st,
    output logic [pfx_pkg::DATA_W-1:0]     value,
    output pfx_pkg::err_t                  status
);

    logic [pfx_pkg::DATA_W-1:0] stack_mem [pfx_pkg::STACK_DEPTH];

    logic [pfx_pkg::SYM_W-1:0]  sym_reg;
    logic                       last_reg;
    logic [pfx_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    pfx_pkg::err_t              err_reg, err_next;
    logic [pfx_pkg::DATA_W-1:0] rd_reg;
    logic                       empty_reg;
    logic [pfx_pkg::DATA_W-1:0] right_reg;
    logic [pfx_pkg::DATA_W-1:0] result_reg;
    logic [pfx_pkg::DATA_W-1:0] value_reg;
    pfx_pkg::err_t              status_reg;

    logic [pfx_pkg::DATA_W-1:0] pop_val;
    logic [pfx_pkg::DATA_W-1:0] push_val;
    logic [pfx_pkg::DATA_W-1:0] alu_val;
    logic [pfx_pkg::DATA_W-1:0] digit_val;
    logic [pfx_pkg::DATA_W-1:0] div_q;
    logic [pfx_pkg::CNT_W-1:0]  cnt_m1;
    logic                       is_digit;
    logic                       is_div;
    logic                       is_bad;
    logic                       right_zero;
    logic                       empty;
    logic                       full;
    logic                       div_done;
    pfx_pkg::err_t              code;

    // Symbol decode
    assign is_digit   = (sym_reg >= pfx_pkg::SYM_ZERO) && (sym_reg <= pfx_pkg::SYM_NINE);
    assign is_div     = (sym_reg == pfx_pkg::SYM_SLASH);
    assign is_bad     = !is_digit && (sym_reg != pfx_pkg::SYM_PLUS)
                        && (sym_reg != pfx_pkg::SYM_MINUS)
                        && (sym_reg != pfx_pkg::SYM_STAR) && !is_div;
    assign right_zero = (right_reg == '0);
    assign digit_val  = pfx_pkg::DATA_W'(sym_reg - pfx_pkg::SYM_ZERO);

    // Stack occupancy
    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg >= pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH));
    assign cnt_m1 = cnt_reg - 1'b1;

    // Popped value: an empty pop yields zero; left operand is used straight from here
    assign pop_val  = empty_reg ? '0 : rd_reg;
    assign push_val = is_digit ? digit_val : result_reg;

    // Add, subtract, multiply; divide and errors give zero here
    always_comb
    begin
        case (sym_reg)
            pfx_pkg::SYM_PLUS:  alu_val = pop_val + right_reg;
            pfx_pkg::SYM_MINUS: alu_val = pop_val - right_reg;
            pfx_pkg::SYM_STAR:  alu_val = pop_val * right_reg;
            default:            alu_val = '0;
        endcase
    end

    // Error source and counter update
    always_comb
    begin
        code     = pfx_pkg::ERR_NONE;
        cnt_next = cnt_reg;
        if (cmd.pop && empty)
        begin
            code = pfx_pkg::ERR_UNDER;
        end
        if (cmd.push && full)
        begin
            code = pfx_pkg::ERR_OVER;
        end
        if (cmd.exec && is_div && right_zero)
        begin
            code = pfx_pkg::ERR_DIVZERO;
        end
        if (cmd.exec && is_bad)
        begin
            code = pfx_pkg::ERR_BADSYM;
        end
        if (cmd.pop && !empty)
        begin
            cnt_next = cnt_m1;
        end
        if (cmd.push && !full)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.fin_load)
        begin
            cnt_next = '0;
        end

        err_next = err_reg;
        if (err_reg == pfx_pkg::ERR_NONE)
        begin
            err_next = code;
        end
        if (cmd.fin_load)
        begin
            err_next = pfx_pkg::ERR_NONE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= pfx_pkg::ERR_NONE;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    // Stack memory, one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            stack_mem[cnt_reg[pfx_pkg::ADDR_W-1:0]] <= push_val;
        end
        if (cmd.pop)
        begin
            rd_reg    <= stack_mem[cnt_m1[pfx_pkg::ADDR_W-1:0]];
            empty_reg <= empty;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sym_reg  <= symbol;
            last_reg <= last;
        end
        if (cmd.load_r)
        begin
            right_reg <= pop_val;
        end
        if (cmd.exec)
        begin
            result_reg <= alu_val;
        end
        else if (div_done)
        begin
            result_reg <= div_q;
        end
        if (cmd.fin_load)
        begin
            value_reg  <= pop_val;
            status_reg <= err_reg;
        end
    end

    // Single divider on operand magnitudes
    pfx_div u_div
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.exec && st.div_go),
        .dividend_mag (pop_val[pfx_pkg::DATA_W-1] ? (~pop_val + 1'b1) : pop_val),
        .divisor_mag  (right_reg[pfx_pkg::DATA_W-1] ? (~right_reg + 1'b1) : right_reg),
        .negate       (pop_val[pfx_pkg::DATA_W-1] ^ right_reg[pfx_pkg::DATA_W-1]),
        .done         (div_done),
        .quotient     (div_q)
    );

    // Status to controller
    always_comb
    begin
        st.in_digit = (symbol >= pfx_pkg::SYM_ZERO) && (symbol <= pfx_pkg::SYM_NINE);
        st.is_last  = last_reg;
        st.div_go   = is_div && !right_zero;
        st.div_done = div_done;
    end

    assign value  = value_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

/* src/pfx_ctrl.sv */
// Controller: sequences pops, evaluation, push and the final pop; owns the handshakes.
`default_nettype none

module pfx_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire pfx_pkg::stat_t st,
    output pfx_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_R,
        S_POP_L,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_FIN_POP,
        S_FIN_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Commands decoded from state
    always_comb
    begin
        cmd.accept   = (state_reg == S_IDLE) && s_tvalid;
        cmd.pop      = (state_reg == S_POP_R) || (state_reg == S_POP_L)
                       || (state_reg == S_FIN_POP);
        cmd.load_r   = (state_reg == S_POP_L);
        cmd.exec     = (state_reg == S_EXEC);
        cmd.push     = (state_reg == S_PUSH);
        cmd.fin_load = (state_reg == S_FIN_OUT) && out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = st.in_digit ? S_PUSH : S_POP_R;
                end
            end
            S_POP_R:   state_next = S_POP_L;
            S_POP_L:   state_next = S_EXEC;
            S_EXEC:    state_next = st.div_go ? S_DIV : S_PUSH;
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:    state_next = st.is_last ? S_FIN_POP : S_IDLE;
            S_FIN_POP: state_next = S_FIN_OUT;
            S_FIN_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fin_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire
